FILE: hdl/multi_timer_bank_macros.svh
// Assertion macros shared by the timer bank RTL.
// No dependencies; included by files that carry assertions.
`ifndef MULTI_TIMER_BANK_MACROS_SVH
`define MULTI_TIMER_BANK_MACROS_SVH

// same-cycle implication
`define MTB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mtb_pkg.sv
// Types, constants and command codes of the timer bank.
// No dependencies; imported by every module of the block.
package mtb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_CREATE = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_START  = 3'd3;
   localparam logic [2:0] OP_STOP   = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  timer_index;
      logic        timer_mode;
      logic [31:0] duration_ms;
   } req_type;

   typedef struct packed {
      logic       error;
      logic [7:0] allocated_index;
      logic       expired_flag;
   } rsp_type;

   typedef struct packed {
      logic             latch;
      logic             tick_step;
      logic             create_step;
      logic             exec;
      logic             load_rsp;
      logic [IDX_W-1:0] scan_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       slot_free;
      logic       scan_free;
   } ctl_status_type;

endpackage

FILE: hdl/mtb_datapath.sv
// Timer state, command word and result register of the timer bank.
// Depends on mtb_pkg; driven by mtb_controller.
module mtb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mtb_pkg::req_type       req_data,
   input  mtb_pkg::ctl_cmd_type   cmd,
   output mtb_pkg::ctl_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mtb_pkg::rsp_type       rsp_data
);
   import mtb_pkg::*;

   req_type                 cmd_ff, cmd_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        found_idx_ff, found_idx_in;
   logic [31:0]             reload_ff [TIMER_COUNT];
   logic [31:0]             reload_in [TIMER_COUNT];
   logic [31:0]             remain_ff [TIMER_COUNT];
   logic [31:0]             remain_in [TIMER_COUNT];
   logic [TIMER_COUNT-1:0]  alloc_ff, alloc_in;
   logic [TIMER_COUNT-1:0]  cont_ff, cont_in;
   logic [TIMER_COUNT-1:0]  run_ff, run_in;
   logic [TIMER_COUNT-1:0]  exp_ff, exp_in;

   logic             in_range;
   logic [IDX_W-1:0] t;
   logic [IDX_W-1:0] s;
   logic [31:0]      dec;
   rsp_type          exec_rsp;

   assign in_range = cmd_ff.timer_index < 8'(TIMER_COUNT);
   assign t = in_range ? cmd_ff.timer_index[IDX_W-1:0] : '0;
   assign s = cmd.scan_idx;
   assign dec = (remain_ff[s] != 32'd0) ? remain_ff[s] - 32'd1 : 32'd0;

   assign status.operation = cmd_ff.operation;
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign status.scan_free = !alloc_ff[s];

   always_comb begin
      cmd_in       = cmd.latch ? req_data : cmd_ff;
      found_in     = cmd.latch ? 1'b0 : found_ff;
      found_idx_in = found_idx_ff;
      reload_in    = reload_ff;
      remain_in    = remain_ff;
      alloc_in     = alloc_ff;
      cont_in      = cont_ff;
      run_in       = run_ff;
      exp_in       = exp_ff;
      exec_rsp     = '0;

      // advance one timer of the tick walk
      if (cmd.tick_step && alloc_ff[s] && run_ff[s]) begin
         remain_in[s] = dec;
         if (dec == 32'd0) begin
            exp_in[s] = 1'b1;
            if (cont_ff[s]) begin
               remain_in[s] = reload_ff[s];
            end else begin
               run_in[s] = 1'b0;
            end
         end
      end

      // claim the free timer found by the create walk
      if (cmd.create_step) begin
         cont_in[s]   = cmd_ff.timer_mode;
         exp_in[s]    = 1'b0;
         reload_in[s] = 32'd0;
         remain_in[s] = 32'd0;
         run_in[s]    = 1'b0;
         alloc_in[s]  = 1'b1;
         found_in     = 1'b1;
         found_idx_in = s;
      end

      unique case (cmd_ff.operation)
         OP_DELETE: begin
            exec_rsp.error = !in_range;
            if (cmd.exec && in_range) begin
               alloc_in[t] = 1'b0;
            end
         end
         OP_START: begin
            exec_rsp.error = !(in_range && alloc_ff[t]);
            if (cmd.exec && in_range && alloc_ff[t]) begin
               reload_in[t] = cmd_ff.duration_ms;
               remain_in[t] = cmd_ff.duration_ms;
               run_in[t]    = 1'b1;
            end
         end
         OP_STOP: begin
            exec_rsp.error = !(in_range && alloc_ff[t]);
            if (cmd.exec && in_range && alloc_ff[t]) begin
               run_in[t] = 1'b0;
            end
         end
         OP_READ: begin
            exec_rsp.error = !in_range;
            if (in_range) begin
               exec_rsp.expired_flag = exp_ff[t];
               if (cmd.exec) begin
                  exp_in[t] = 1'b0;
               end
            end
         end
         OP_TICK: begin
            exec_rsp = '0;
         end
         OP_CREATE: begin
            exec_rsp.error = !found_ff;
            exec_rsp.allocated_index = found_ff ? 8'(found_idx_ff) : 8'd0;
         end
         default: begin
            exec_rsp.error = 1'b1;
         end
      endcase

      rsp_in       = cmd.load_rsp ? exec_rsp : rsp_ff;
      rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         alloc_ff     <= '0;
         cont_ff      <= '0;
         run_ff       <= '0;
         exp_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         alloc_ff     <= alloc_in;
         cont_ff      <= cont_in;
         run_ff       <= run_in;
         exp_ff       <= exp_in;
         found_ff     <= found_in;
      end
      cmd_ff       <= cmd_in;
      rsp_ff       <= rsp_in;
      found_idx_ff <= found_idx_in;
      reload_ff    <= reload_in;
      remain_ff    <= remain_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/mtb_controller.sv
// Command sequencer of the timer bank: accept, timer walk, result hand-off.
// Depends on mtb_pkg and the assertion macros; drives mtb_datapath.
`include "multi_timer_bank_macros.svh"
module mtb_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mtb_pkg::ctl_status_type status,
   output mtb_pkg::ctl_cmd_type    cmd
);
   import mtb_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             last;

   assign last = scan_ff == IDX_W'(TIMER_COUNT - 1);
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      cmd          = '0;
      cmd.scan_idx = scan_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.operation == OP_TICK || status.operation == OP_CREATE) begin
               scan_in  = '0;
               state_in = S_SCAN;
            end else if (status.slot_free) begin
               cmd.exec     = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            if (status.operation == OP_TICK) begin
               cmd.tick_step = 1'b1;
               if (last) begin
                  state_in = S_DONE;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end else if (status.scan_free) begin
               cmd.create_step = 1'b1;
               state_in        = S_DONE;
            end else if (last) begin
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (status.slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      scan_ff <= scan_in;
   end

   `MTB_ASSERT_NOW(a_load_needs_slot, clock, reset, cmd.load_rsp, status.slot_free, "result loaded over a waiting word")
   `MTB_ASSERT_NOW(a_one_walk_kind, clock, reset, cmd.tick_step, !cmd.create_step && !cmd.exec, "tick walk overlaps another update")
   `MTB_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_valid && !req_stall, state_ff == S_EXEC, "accepted word not decoded")
   `MTB_ASSERT_NEXT(a_load_to_idle, clock, reset, cmd.load_rsp, state_ff == S_IDLE && !req_stall, "controller busy after result")

endmodule

FILE: hdl/multi_timer_bank.sv
// Bank of millisecond countdown timers driven by one command word at a time.
// Depends on mtb_pkg, mtb_controller and mtb_datapath.
//
// Request channel (req_valid, req_stall, req_data): one command word per
// handshake - tick, create, delete, start, stop or read-and-clear-expired.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one word per
// command, in command order, carrying error, allocated index and flag.
// Delete, start, stop, read and unknown codes are latched, then executed in
// the decode state, which loads the response register. A tick walks every
// timer, one per cycle, then loads its response. A create walks from timer 0
// to the lowest free one, or through all timers if none is free. The walk
// sets the rate: one command is in work at a time, and the next is taken
// the cycle after the response is loaded.
// Reset clears every timer's flags and the response valid flag; no clearing
// pass is needed. While the receiver stalls, the response word is held
// and a finished command waits in the sequencer until the register frees.
module multi_timer_bank (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtb_pkg::rsp_type rsp_data
);
   import mtb_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   mtb_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mtb_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for multi_timer_bank: directed and random command words,
// with a built-in timer bank predictor and in-order response checking.
// Depends on mtb_pkg and multi_timer_bank.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtb_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int RANDOM_PER_PHASE = 290;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   bit      word_live = 1'b0;
   int      send_idle_pct = 8;
   int      recv_idle_pct = 78;
   int      fail_count = 0;

   logic [31:0] timer_reload[TIMER_COUNT];
   logic [31:0] timer_remaining[TIMER_COUNT];
   bit          timer_allocated[TIMER_COUNT];
   bit          timer_continuous[TIMER_COUNT];
   bit          timer_running[TIMER_COUNT];
   bit          timer_expired[TIMER_COUNT];

   multi_timer_bank dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rsp_type bank_response(input req_type cmd);
      rsp_type r;
      bit      in_range;
      int      t;
      int      k;
      r = '0;
      in_range = cmd.timer_index < TIMER_COUNT;
      t = in_range ? int'(cmd.timer_index) : 0;
      case (cmd.operation)
         OP_TICK: begin
            for (k = 0; k < TIMER_COUNT; k++) begin
               if (timer_allocated[k] && timer_running[k]) begin
                  if (timer_remaining[k] != 0) timer_remaining[k] = timer_remaining[k] - 1;
                  if (timer_remaining[k] == 0) begin
                     timer_expired[k] = 1'b1;
                     if (timer_continuous[k]) timer_remaining[k] = timer_reload[k];
                     else timer_running[k] = 1'b0;
                  end
               end
            end
         end
         OP_CREATE: begin
            k = 0;
            while (k < TIMER_COUNT && timer_allocated[k]) k++;
            if (k >= TIMER_COUNT) begin
               r.error = 1'b1;
            end else begin
               timer_continuous[k] = cmd.timer_mode;
               timer_expired[k] = 1'b0;
               timer_reload[k] = '0;
               timer_remaining[k] = '0;
               timer_running[k] = 1'b0;
               timer_allocated[k] = 1'b1;
               r.allocated_index = 8'(k);
            end
         end
         OP_DELETE: begin
            if (!in_range) r.error = 1'b1;
            else timer_allocated[t] = 1'b0;
         end
         OP_START: begin
            if (!in_range || !timer_allocated[t]) begin
               r.error = 1'b1;
            end else begin
               timer_reload[t] = cmd.duration_ms;
               timer_remaining[t] = cmd.duration_ms;
               timer_running[t] = 1'b1;
            end
         end
         OP_STOP: begin
            if (!in_range || !timer_allocated[t]) r.error = 1'b1;
            else timer_running[t] = 1'b0;
         end
         OP_READ: begin
            if (!in_range) begin
               r.error = 1'b1;
            end else begin
               r.expired_flag = timer_expired[t];
               timer_expired[t] = 1'b0;
            end
         end
         default: r.error = 1'b1;
      endcase
      return r;
   endfunction

   // advance the bank model on each accepted word and check each response word
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(bank_response(req_data));
         void'(pending_cmds.pop_front());
         word_live = 1'b0;
      end
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("response word with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.error !== want.error) begin
               $error("error: expected %0d actual %0d", want.error, rsp_data.error);
               fail_count++;
            end
            if (rsp_data.allocated_index !== want.allocated_index) begin
               $error("allocated_index: expected %0d actual %0d",
                      want.allocated_index, rsp_data.allocated_index);
               fail_count++;
            end
            if (rsp_data.expired_flag !== want.expired_flag) begin
               $error("expired_flag: expected %0d actual %0d",
                      want.expired_flag, rsp_data.expired_flag);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (word_live) begin
         req_valid <= 1'b1;
      end else if (!reset && pending_cmds.size() != 0 &&
                   $urandom_range(99, 0) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_data <= pending_cmds[0];
         word_live = 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
      rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
   end

   task automatic push_cmd(input logic [2:0] op, input int idx, input bit mode,
                           input logic [31:0] dur);
      req_type c;
      c.operation = op;
      c.timer_index = 8'(idx);
      c.timer_mode = mode;
      c.duration_ms = dur;
      pending_cmds.push_back(c);
   endtask

   task automatic add_random_cmds(input int count);
      req_type c;
      int      pick;
      int      n;
      for (n = 0; n < count; n++) begin
         c.timer_mode = 1'($urandom);
         c.timer_index = ($urandom_range(99, 0) < 85) ? 8'($urandom_range(TIMER_COUNT - 1, 0))
                                                      : 8'($urandom_range(255, TIMER_COUNT));
         pick = $urandom_range(99, 0);
         if (pick < 70) c.duration_ms = $urandom_range(6, 0);
         else if (pick < 90) c.duration_ms = $urandom_range(40, 7);
         else c.duration_ms = $urandom;
         pick = $urandom_range(99, 0);
         if (pick < 35) c.operation = OP_TICK;
         else if (pick < 47) c.operation = OP_CREATE;
         else if (pick < 55) c.operation = OP_DELETE;
         else if (pick < 75) c.operation = OP_START;
         else if (pick < 82) c.operation = OP_STOP;
         else if (pick < 97) c.operation = OP_READ;
         else c.operation = pick[0] ? OP_UNUSED_HI : OP_UNUSED_LO;
         pending_cmds.push_back(c);
      end
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || word_live || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int k;
      for (k = 0; k < TIMER_COUNT; k++) begin
         timer_reload[k] = '0;
         timer_remaining[k] = '0;
         timer_allocated[k] = 1'b0;
         timer_continuous[k] = 1'b0;
         timer_running[k] = 1'b0;
         timer_expired[k] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_cmd(OP_TICK, 0, 1'b0, 32'd0);
      push_cmd(OP_READ, 0, 1'b0, 32'd0);
      push_cmd(OP_START, 0, 1'b0, 32'd5);
      push_cmd(OP_STOP, TIMER_COUNT - 1, 1'b0, 32'd0);
      for (k = 0; k <= TIMER_COUNT; k++) push_cmd(OP_CREATE, 0, k % 2 == 0, 32'd0);
      push_cmd(OP_START, 0, 1'b0, 32'd0);
      push_cmd(OP_START, 1, 1'b0, 32'd1);
      push_cmd(OP_START, TIMER_COUNT - 1, 1'b0, 32'hFFFF_FFFF);
      push_cmd(OP_TICK, 0, 1'b0, 32'd0);
      push_cmd(OP_DELETE, 1, 1'b0, 32'd0);
      push_cmd(OP_READ, 1, 1'b0, 32'd0);
      push_cmd(OP_READ, 0, 1'b1, 32'd0);
      push_cmd(OP_READ, TIMER_COUNT, 1'b0, 32'd0);
      push_cmd(OP_DELETE, 255, 1'b1, 32'hFFFF_FFFF);
      push_cmd(OP_UNUSED_LO, 3, 1'b0, 32'd0);
      push_cmd(OP_UNUSED_HI, 255, 1'b1, 32'hFFFF_FFFF);
      push_cmd(OP_STOP, 0, 1'b0, 32'd0);
      push_cmd(OP_TICK, 0, 1'b0, 32'd0);
      push_cmd(OP_READ, 0, 1'b0, 32'd0);
      // hold the sender until every response word is back
      drain();

      add_random_cmds(RANDOM_PER_PHASE);
      drain();
      send_idle_pct = 78;
      recv_idle_pct = 8;
      add_random_cmds(RANDOM_PER_PHASE);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_cmds(RANDOM_PER_PHASE);
      drain();
      repeat (4 * TIMER_COUNT + 20) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS multi_timer_bank");
      end else begin
         $display("FAIL multi_timer_bank");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL multi_timer_bank");
      $finish;
   end

endmodule
